/* src/jsu_pkg.sv */
// shared types and constants for the json string unescaper
// holds the channel words, the front-to-back operation word and the reset values
// no dependencies
package jsu_pkg;

	localparam int unsigned OP_BYTES = 4;
	localparam int unsigned FIFO_DEPTH = 4;
	localparam logic [15:0] CAP_RESET = 16'd1024;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_ERROR = 2'd2
	} out_kind_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_first;
		logic       in_last;
	} in_word_t;

	typedef struct packed {
		out_kind_t   out_kind;
		logic [7:0]  out_byte;
		logic [15:0] out_length;
		logic        out_last;
	} out_word_t;

	// one classified input word: a start or error mark, bytes to write, then an optional done
	typedef struct packed {
		logic                     start;
		logic                     error;
		logic [2:0]               nbytes;
		logic                     atomic;
		logic                     fin;
		logic [OP_BYTES-1:0][7:0] bytes;
	} op_t;

endpackage

/* src/jsu_fifo.sv */
// short operation queue between the classifier and the writer
// flop-based storage, depth set by the top level; uses jsu_pkg
module jsu_fifo import jsu_pkg::*; #(
	parameter int unsigned Depth = FIFO_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	input  logic pop,
	output op_t  head,
	output logic empty
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	op_t             mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full  = count_q == CntW'(Depth);
	assign empty = count_q == '0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

`ifndef ASSERT_OFF
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("pop from empty queue");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + CntW'(1)))
		else $error("queue count did not follow push");
`endif

endmodule

/* src/jsu_front.sv */
// classifier: tracks string, escape and hex state per input word
// turns each word into at most one operation for the writer; uses jsu_pkg
module jsu_front import jsu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_word_t in_data,
	input  logic     full,
	output logic     push,
	output op_t      push_op
);

	typedef enum logic [1:0] {
		M_IDLE,
		M_BODY,
		M_ESC,
		M_HEX
	} mode_t;

	typedef struct packed {
		mode_t           mode;
		logic            fin;
		logic [1:0]      n;
		logic [1:0][7:0] b;
	} pstep_t;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_U = 8'h75;
	localparam logic [7:0] CH_N = 8'h6e;
	localparam logic [7:0] CH_R = 8'h72;
	localparam logic [7:0] CH_T = 8'h74;
	localparam logic [7:0] CH_B = 8'h62;
	localparam logic [7:0] CH_F = 8'h66;
	localparam logic [15:0] UTF_LIM1 = 16'h0080;
	localparam logic [15:0] UTF_LIM2 = 16'h0800;
	localparam logic [7:0] LEAD2 = 8'hc0;
	localparam logic [7:0] LEAD3 = 8'he0;
	localparam logic [7:0] CONT = 8'h80;

	// {valid, value}
	function automatic logic [4:0] hex_digit(logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	// one byte in body or escape mode; hex mode here only as replay of a lone u at the end
	function automatic pstep_t plain_step(mode_t m, logic [7:0] c, logic at_end);
		pstep_t r;
		r = '0;
		r.mode = m;
		unique case (m)
			M_IDLE: begin
			end
			M_BODY: begin
				if (c == CH_QUOTE) begin
					r.fin = 1'b1;
					r.mode = M_IDLE;
				end else if (c == CH_BSLASH && !at_end) begin
					r.mode = M_ESC;
				end else begin
					r.n = 2'd1;
					r.b[0] = c;
				end
			end
			M_ESC: begin
				r.mode = M_BODY;
				if (c == CH_U && !at_end) begin
					r.mode = M_HEX;
				end else begin
					unique case (c) inside
						CH_N, CH_R, CH_T: begin
							r.n = 2'd1;
							r.b[0] = CH_SPACE;
						end
						CH_B, CH_F: begin
						end
						default: begin
							r.n = 2'd1;
							r.b[0] = c;
						end
					endcase
				end
			end
			M_HEX: begin
				r.mode = M_BODY;
				r.n = 2'd1;
				r.b[0] = CH_U;
				if (c != CH_QUOTE) begin
					r.n = 2'd2;
					r.b[1] = c;
				end
			end
		endcase
		if (at_end) begin
			r.fin = 1'b1;
			r.mode = M_IDLE;
		end
		return r;
	endfunction

	mode_t       mode_q, mode_n;
	logic [1:0]  hex_count_q, hex_count_n;
	logic [15:0] hex_accum_q, hex_accum_n;
	logic        hex_invalid_q, hex_invalid_n;
	logic [7:0]  held_q [2];
	logic        held_we;
	logic        accept;

	assign in_stall = full;
	assign accept = in_valid && !full;

	always_comb begin
		pstep_t          s;
		logic [4:0]      dig;
		logic            inval;
		logic [15:0]     acc;
		logic [7:0]      c;
		logic [3:0][7:0] lst;
		logic [2:0]      cnt;
		logic            alive;
		mode_t           m;
		mode_n = mode_q;
		hex_count_n = hex_count_q;
		hex_accum_n = hex_accum_q;
		hex_invalid_n = hex_invalid_q;
		held_we = 1'b0;
		push = 1'b0;
		push_op = '0;
		s = '0;
		c = '0;
		lst = '0;
		cnt = '0;
		alive = 1'b0;
		m = M_BODY;
		dig = hex_digit(in_data.in_byte);
		inval = hex_invalid_q | ~dig[4];
		acc = dig[4] ? {hex_accum_q[11:0], dig[3:0]} : hex_accum_q;
		if (accept) begin
			if (in_data.in_first) begin
				hex_count_n = '0;
				hex_accum_n = '0;
				hex_invalid_n = 1'b0;
				push = 1'b1;
				if (in_data.in_byte != CH_QUOTE) begin
					push_op.error = 1'b1;
					mode_n = M_IDLE;
				end else begin
					push_op.start = 1'b1;
					push_op.fin = in_data.in_last;
					mode_n = in_data.in_last ? M_IDLE : M_BODY;
				end
			end else begin
				unique case (mode_q)
					M_IDLE: begin
					end
					M_BODY, M_ESC: begin
						s = plain_step(mode_q, in_data.in_byte, in_data.in_last);
						mode_n = s.mode;
						if (s.mode == M_HEX) begin
							hex_count_n = '0;
							hex_accum_n = '0;
							hex_invalid_n = 1'b0;
						end
						push_op.nbytes = {1'b0, s.n};
						push_op.bytes[0] = s.b[0];
						push_op.bytes[1] = s.b[1];
						push_op.fin = s.fin;
						push = (s.n != 2'd0) || s.fin;
					end
					M_HEX: begin
						if (hex_count_q == 2'd3) begin
							mode_n = in_data.in_last ? M_IDLE : M_BODY;
							hex_count_n = '0;
							hex_accum_n = acc;
							hex_invalid_n = inval;
							push_op.atomic = 1'b1;
							push_op.fin = in_data.in_last;
							if (!inval) begin
								if (acc < UTF_LIM1) begin
									push_op.nbytes = 3'd1;
									push_op.bytes[0] = acc[7:0];
								end else if (acc < UTF_LIM2) begin
									push_op.nbytes = 3'd2;
									push_op.bytes[0] = LEAD2 | {3'b000, acc[10:6]};
									push_op.bytes[1] = CONT | {2'b00, acc[5:0]};
								end else begin
									push_op.nbytes = 3'd3;
									push_op.bytes[0] = LEAD3 | {4'h0, acc[15:12]};
									push_op.bytes[1] = CONT | {2'b00, acc[11:6]};
									push_op.bytes[2] = CONT | {2'b00, acc[5:0]};
								end
							end
							push = !inval || in_data.in_last;
						end else if (in_data.in_last) begin
							// buffer ends inside the escape: u, then held digits and this byte as text
							lst[0] = CH_U;
							cnt = 3'd1;
							alive = 1'b1;
							for (int i = 0; i < 3; i++) begin
								if (alive && 2'(i) <= hex_count_q) begin
									c = (2'(i) == hex_count_q) ? in_data.in_byte : held_q[1'(i)];
									s = plain_step(m, c, 2'(i) == hex_count_q);
									if (s.n != 2'd0) begin
										lst[cnt[1:0]] = s.b[0];
										cnt = cnt + 3'd1;
									end
									if (s.n == 2'd2) begin
										lst[cnt[1:0]] = s.b[1];
										cnt = cnt + 3'd1;
									end
									m = s.mode;
									if (s.fin) begin
										alive = 1'b0;
									end
								end
							end
							push_op.nbytes = cnt;
							push_op.bytes = lst;
							push_op.fin = 1'b1;
							mode_n = M_IDLE;
							hex_count_n = '0;
							push = 1'b1;
						end else begin
							hex_count_n = hex_count_q + 2'd1;
							hex_accum_n = acc;
							hex_invalid_n = inval;
							held_we = hex_count_q != 2'd2;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			hex_count_q <= '0;
			hex_accum_q <= '0;
			hex_invalid_q <= 1'b0;
		end else begin
			mode_q <= mode_n;
			hex_count_q <= hex_count_n;
			hex_accum_q <= hex_accum_n;
			hex_invalid_q <= hex_invalid_n;
		end
	end

	always_ff @(posedge clk) begin
		if (held_we) begin
			held_q[hex_count_q[0]] <= in_data.in_byte;
		end
	end

endmodule

/* src/jsu_back.sv */
// writer: plays out queued operations one result word per cycle while out_stall allows
// owns the byte count and the capacity check; uses jsu_pkg
module jsu_back import jsu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] cap,
	input  op_t         head,
	input  logic        empty,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output out_word_t   out_data
);

	logic [15:0] cnt_q, cnt_n, cnt_base;
	logic        drop_q, drop_n, drop_base;
	logic [2:0]  pos_q, pos_n;
	logic        out_valid_q;
	out_word_t   out_q;
	out_word_t   word;
	logic        room, emit, done_pop, advance, load, fail;
	logic [2:0]  need;
	logic [16:0] need_sum;

	always_comb begin
		cnt_base = head.start ? '0 : cnt_q;
		drop_base = head.start ? 1'b0 : drop_q;
		room = !out_valid_q || !out_stall;
		need = head.atomic ? ((pos_q == 3'd0) ? head.nbytes : 3'd0) : 3'd1;
		need_sum = {1'b0, cnt_base} + {14'd0, need};
		fail = (need != 3'd0) && (need_sum >= {1'b0, cap});
		emit = 1'b0;
		done_pop = 1'b0;
		word = '0;
		word.out_kind = KIND_DATA;
		cnt_n = cnt_q;
		drop_n = drop_q;
		pos_n = pos_q;
		if (!empty) begin
			if (head.error) begin
				emit = 1'b1;
				word.out_kind = KIND_ERROR;
				word.out_last = 1'b1;
				done_pop = 1'b1;
				cnt_n = '0;
				drop_n = 1'b0;
				pos_n = '0;
			end else if (pos_q < head.nbytes && !drop_base) begin
				emit = 1'b1;
				if (fail) begin
					// no room left: close the string now and skip until the next start
					word.out_kind = KIND_DONE;
					word.out_length = cnt_base;
					word.out_last = 1'b1;
					done_pop = 1'b1;
					cnt_n = cnt_base;
					drop_n = 1'b1;
					pos_n = '0;
				end else begin
					word.out_byte = head.bytes[pos_q[1:0]];
					cnt_n = cnt_base + 16'd1;
					drop_n = drop_base;
					if (pos_q + 3'd1 == head.nbytes && !head.fin) begin
						done_pop = 1'b1;
						pos_n = '0;
					end else begin
						pos_n = pos_q + 3'd1;
					end
				end
			end else if (head.fin && !drop_base) begin
				emit = 1'b1;
				word.out_kind = KIND_DONE;
				word.out_length = cnt_base;
				word.out_last = 1'b1;
				done_pop = 1'b1;
				cnt_n = cnt_base;
				drop_n = 1'b1;
				pos_n = '0;
			end else begin
				done_pop = 1'b1;
				cnt_n = cnt_base;
				drop_n = drop_base;
				pos_n = '0;
			end
		end
		advance = !empty && (!emit || room);
		pop = advance && done_pop;
		load = advance && emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			drop_q <= 1'b0;
			pos_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				cnt_q <= cnt_n;
				drop_q <= drop_n;
				pos_q <= pos_n;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= word;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

`ifndef ASSERT_OFF
	a_data_below_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(load && word.out_kind == KIND_DATA) |-> (({1'b0, cnt_base} + 17'd1) < {1'b0, cap}))
		else $error("data word written at or beyond capacity");
	a_done_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(load && word.out_kind == KIND_DONE) |=> drop_q)
		else $error("writer still open after done word");
	a_partial_head: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q != 3'd0) |-> !empty)
		else $error("partly written operation left the queue");
`endif

endmodule

/* src/json_string_unescape_utf8.sv */
// Unescapes one quoted JSON string per in_first-marked run of input words into UTF-8 bytes.
// Input channel: in_valid/in_stall with in_data (byte, first, last); one byte per word.
// Output channel: out_valid/out_stall with out_data; data words, then one done word with
// the written length and out_last set, or a single error word when the first byte is no quote.
// Config: cfg_we/cfg_wdata writes the output capacity; at most capacity minus one data bytes
// are written per string; write it only while the block is idle.
// A result word passes through the operation queue and the writer's output register to out_valid.
// Throughput: one input word per cycle while the operation queue is not full; a word that
// yields k results (up to five) holds the writer until all k are written, and the queue
// of FifoDepth entries between classifier and writer absorbs the difference.
// in_stall rises only when that queue is full; the writer alone waits on out_stall, with
// its output register holding the word, while the classifier keeps taking input.
// Reset: idle, capacity 1024, queue and output empty.
// Depends on jsu_pkg, jsu_front, jsu_fifo, jsu_back.
module json_string_unescape_utf8 import jsu_pkg::*; #(
	parameter int unsigned FifoDepth = FIFO_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_word_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_word_t   out_data,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	logic [15:0] cap_q;
	logic        full, push, pop, empty;
	op_t         push_op, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	jsu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.full     (full),
		.push     (push),
		.push_op  (push_op)
	);

	jsu_fifo #(
		.Depth (FifoDepth)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (full),
		.pop     (pop),
		.head    (head),
		.empty   (empty)
	);

	jsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cap       (cap_q),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

/* dv/tb_json_string_unescape_utf8.sv */
// testbench for json_string_unescape_utf8: directed table, then random strings per capacity
// every output word is checked in order against the directed table's result or a behavioral unescaper kept in this file
// depends on jsu_pkg and the json_string_unescape_utf8 rtl
module tb_json_string_unescape_utf8 import jsu_pkg::*;;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_U      = "u";
	localparam logic [7:0] CH_N      = "n";
	localparam logic [7:0] CH_R      = "r";
	localparam logic [7:0] CH_T      = "t";
	localparam logic [7:0] CH_B      = "b";
	localparam logic [7:0] CH_F      = "f";
	localparam int IDLE_PCT      = 18;
	localparam int DRAIN_CYCLES  = 12;
	localparam int PHASE_WORDS   = 25;
	localparam int LONG_HOLD     = 120;
	localparam int HOLD_PHASE    = 3;
	localparam int QUIET_PHASE   = 5;
	localparam int NUM_PHASES    = 8;
	localparam int MAX_REPORTS   = 10;

	typedef enum logic [1:0] {PM_IDLE, PM_BODY, PM_ESC, PM_HEX} parse_mode_t;

	typedef struct {
		bit          set_cap;
		logic [15:0] cap;
		in_word_t    w;
		bit          typed;
		bit          has_res;
		out_word_t   res;
	} drow_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_word_t    in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_word_t   out_data;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	// unescaper state
	int          cap_val;
	parse_mode_t pmode;
	logic [1:0]  hex_cnt;
	logic [15:0] hex_val;
	bit          hex_bad;
	logic [7:0]  held [3];
	int          nwritten;

	out_word_t   fresh_q [$];
	out_word_t   exp_q [$];
	in_word_t    str_q [$];
	drow_t       dir_rows [$];
	logic [15:0] cap_plan [NUM_PHASES] = '{16'd1024, 16'd1, 16'd65535, 16'd7, 16'd0,
		16'd16, 16'd2, 16'd40};

	int words_in = 0;
	int busy_items = 0;
	int words_checked = 0;
	int strings_done = 0;
	int strings_bad = 0;
	int mism = 0;
	int phase_no = -1;
	bit quiet = 1'b0;
	int hold_left = 0;
	bit long_hold_done = 1'b0;

	json_string_unescape_utf8 DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	function automatic void put_word(out_kind_t k, logic [7:0] b, logic [15:0] len);
		out_word_t x;
		x.out_kind = k;
		x.out_byte = b;
		x.out_length = len;
		x.out_last = (k != KIND_DATA);
		fresh_q.push_back(x);
	endfunction

	function automatic void close_string();
		put_word(KIND_DONE, 8'h00, nwritten[15:0]);
		pmode = PM_IDLE;
	endfunction

	function automatic bit emit_bytes(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, int k);
		logic [7:0] b [3];
		b = '{b0, b1, b2};
		if (nwritten + k >= cap_val)
			return 1'b0;
		for (int i = 0; i < k; i++)
			put_word(KIND_DATA, b[i], 16'd0);
		nwritten = nwritten + k;
		return 1'b1;
	endfunction

	function automatic bit emit_utf8(logic [15:0] v);
		if (v < 16'h0080)
			return emit_bytes(v[7:0], 8'h00, 8'h00, 1);
		if (v < 16'h0800)
			return emit_bytes({3'b110, v[10:6]}, {2'b10, v[5:0]}, 8'h00, 2);
		return emit_bytes({4'b1110, v[15:12]}, {2'b10, v[11:6]}, {2'b10, v[5:0]}, 3);
	endfunction

	function automatic int hex_digit(logic [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "a" && c <= "f") return c - "a" + 10;
		if (c >= "A" && c <= "F") return c - "A" + 10;
		return -1;
	endfunction

	// fills fresh_q with the words one accepted input word causes
	function automatic void unescape_step(in_word_t w);
		logic [7:0] q [4];
		int qlen;
		int qpos;
		logic [7:0] c;
		bit at_end;
		int d;
		fresh_q.delete();
		if (w.in_first) begin
			hex_cnt = '0;
			hex_val = '0;
			hex_bad = 1'b0;
			nwritten = 0;
			if (w.in_byte != CH_QUOTE) begin
				put_word(KIND_ERROR, 8'h00, 16'd0);
				pmode = PM_IDLE;
				return;
			end
			pmode = PM_BODY;
			if (w.in_last)
				close_string();
			return;
		end
		if (pmode == PM_IDLE)
			return;
		q[0] = w.in_byte;
		qlen = 1;
		qpos = 0;
		while (qpos < qlen && pmode != PM_IDLE) begin
			c = q[qpos];
			qpos++;
			at_end = w.in_last && qpos == qlen;
			case (pmode)
				PM_BODY: begin
					if (c == CH_QUOTE)
						close_string();
					else if (c == CH_BSLASH && !at_end)
						pmode = PM_ESC;
					else if (!emit_bytes(c, 8'h00, 8'h00, 1) || at_end)
						close_string();
				end
				PM_ESC: begin
					pmode = PM_BODY;
					if (c == CH_U && !at_end) begin
						pmode = PM_HEX;
						hex_cnt = '0;
						hex_val = '0;
						hex_bad = 1'b0;
					end else if (c == CH_B || c == CH_F) begin
						if (at_end)
							close_string();
					end else begin
						if (c == CH_N || c == CH_R || c == CH_T)
							c = CH_SPACE;
						if (!emit_bytes(c, 8'h00, 8'h00, 1) || at_end)
							close_string();
					end
				end
				PM_HEX: begin
					if (hex_cnt == 2'd3) begin
						d = hex_digit(c);
						if (d < 0)
							hex_bad = 1'b1;
						else
							hex_val = {hex_val[11:0], d[3:0]};
						pmode = PM_BODY;
						if (!hex_bad && !emit_utf8(hex_val))
							close_string();
						else if (at_end)
							close_string();
					end else if (at_end) begin
						// replay u, then the held digits and this byte as string text
						for (int i = 0; i < hex_cnt; i++)
							q[i] = held[i];
						q[hex_cnt] = c;
						qlen = hex_cnt + 1;
						qpos = 0;
						pmode = PM_BODY;
						if (!emit_bytes(CH_U, 8'h00, 8'h00, 1))
							close_string();
					end else begin
						d = hex_digit(c);
						if (d < 0)
							hex_bad = 1'b1;
						else
							hex_val = {hex_val[11:0], d[3:0]};
						held[hex_cnt] = c;
						hex_cnt++;
					end
				end
				default: pmode = PM_IDLE;
			endcase
		end
	endfunction

	function automatic void check_word(out_word_t got);
		out_word_t want;
		if (exp_q.size() == 0) begin
			mism++;
			if (mism <= MAX_REPORTS)
				$display("unexpected word: kind %0d byte %02h len %0d last %0b",
					got.out_kind, got.out_byte, got.out_length, got.out_last);
			return;
		end
		want = exp_q.pop_front();
		words_checked++;
		if (want.out_kind == KIND_DONE) strings_done++;
		if (want.out_kind == KIND_ERROR) strings_bad++;
		if (got.out_kind !== want.out_kind || got.out_byte !== want.out_byte ||
				got.out_length !== want.out_length || got.out_last !== want.out_last) begin
			mism++;
			if (mism <= MAX_REPORTS) begin
				$display("word %0d: expected kind %0d byte %02h len %0d last %0b",
					words_checked, want.out_kind, want.out_byte, want.out_length,
					want.out_last);
				$display("  got kind %0d byte %02h len %0d last %0b",
					got.out_kind, got.out_byte, got.out_length, got.out_last);
			end
		end
	endfunction

	// receiver: checks accepted words and drives out_stall
	always @(posedge clk) begin
		if (out_valid && !out_stall)
			check_word(out_data);
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (phase_no == HOLD_PHASE && !long_hold_done) begin
			out_stall <= 1'b1;
			hold_left <= LONG_HOLD;
			long_hold_done <= 1'b1;
		end else begin
			out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
		end
	end

	function automatic drow_t raw(logic [7:0] b, bit f, bit l);
		drow_t r;
		r = '{set_cap: 1'b0, cap: '0, w: '0, typed: 1'b0, has_res: 1'b0, res: '0};
		r.w.in_byte = b;
		r.w.in_first = f;
		r.w.in_last = l;
		return r;
	endfunction

	function automatic drow_t typed_row(logic [7:0] b, bit f, bit l, bit has, out_kind_t k,
			logic [15:0] len);
		drow_t r;
		r = raw(b, f, l);
		r.typed = 1'b1;
		r.has_res = has;
		r.res.out_kind = k;
		r.res.out_byte = 8'h00;
		r.res.out_length = len;
		r.res.out_last = 1'b1;
		return r;
	endfunction

	function automatic drow_t cap_row(logic [15:0] v);
		drow_t r;
		r = raw(8'h00, 1'b0, 1'b0);
		r.set_cap = 1'b1;
		r.cap = v;
		return r;
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
		if (n < 4'd10)
			return "0" + n;
		return 8'((upper ? "A" : "a") + n - 10);
	endfunction

	function automatic logic [7:0] esc_letter();
		case ($urandom_range(9))
			0: return CH_N;
			1: return CH_R;
			2: return CH_T;
			3: return CH_B;
			4: return CH_F;
			5: return CH_QUOTE;
			6: return CH_BSLASH;
			7: return "/";
			8: return CH_U;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic void push_byte(logic [7:0] b, bit f, bit l);
		in_word_t w;
		w.in_byte = b;
		w.in_first = f;
		w.in_last = l;
		str_q.push_back(w);
	endfunction

	function automatic logic [15:0] code_point();
		case ($urandom_range(5))
			0: return 16'($urandom_range(16'h007F));
			1: return 16'($urandom_range(16'h07FF, 16'h0080));
			2: return 16'($urandom_range(16'hFFFF, 16'h0800));
			3: case ($urandom_range(5))
				0: return 16'h0000;
				1: return 16'h007F;
				2: return 16'h0080;
				3: return 16'h07FF;
				4: return 16'h0800;
				default: return 16'hFFFF;
			endcase
			default: return 16'($urandom_range(16'hFFFF));
		endcase
	endfunction

	// one random string, mostly well formed, into str_q
	function automatic void build_string();
		int n;
		int bad_pos;
		logic [7:0] b;
		logic [15:0] v;
		logic [7:0] digits [4];
		str_q.delete();
		case ($urandom_range(99)) inside
			[0:9]: begin
				n = $urandom_range(6, 1);
				for (int i = 0; i < n; i++)
					push_byte(8'($urandom_range(255)), $urandom_range(3) == 0,
						$urandom_range(7) == 0);
			end
			[10:15]: begin
				b = 8'($urandom_range(255));
				if (b == CH_QUOTE) b = CH_BSLASH;
				push_byte(b, 1'b1, 1'($urandom_range(1)));
				n = $urandom_range(2);
				for (int i = 0; i < n; i++)
					push_byte(8'($urandom_range(255)), 1'b0, 1'b0);
			end
			default: begin
				push_byte(CH_QUOTE, 1'b1, 1'b0);
				n = $urandom_range(10);
				for (int i = 0; i < n; i++) begin
					case ($urandom_range(9)) inside
						[0:4]: begin
							b = 8'($urandom_range(255));
							if (b == CH_QUOTE || b == CH_BSLASH) b = "a";
							push_byte(b, 1'b0, 1'b0);
						end
						[5:6]: begin
							push_byte(CH_BSLASH, 1'b0, 1'b0);
							push_byte(esc_letter(), 1'b0, 1'b0);
						end
						default: begin
							v = code_point();
							for (int k = 0; k < 4; k++)
								digits[k] = hex_char(v[15-4*k -: 4],
									1'($urandom_range(1)));
							if ($urandom_range(7) == 0) begin
								bad_pos = $urandom_range(3);
								case ($urandom_range(2))
									0: digits[bad_pos] = CH_QUOTE;
									1: digits[bad_pos] = "G";
									default: digits[bad_pos] = 8'hFF;
								endcase
							end
							push_byte(CH_BSLASH, 1'b0, 1'b0);
							push_byte(CH_U, 1'b0, 1'b0);
							for (int k = 0; k < 4; k++)
								push_byte(digits[k], 1'b0, 1'b0);
						end
					endcase
				end
				case ($urandom_range(11)) inside
					[0:5]: push_byte(CH_QUOTE, 1'b0, $urandom_range(9) == 0);
					[6:7]: str_q[str_q.size()-1].in_last = 1'b1;
					8: begin
						push_byte(CH_BSLASH, 1'b0, 1'b0);
						push_byte(CH_U, 1'b0, 1'b0);
						n = $urandom_range(3);
						for (int k = 0; k < n; k++)
							push_byte(hex_char(4'($urandom_range(15)),
								1'($urandom_range(1))), 1'b0, 1'b0);
						str_q[str_q.size()-1].in_last = 1'b1;
					end
					9: push_byte(CH_BSLASH, 1'b0, 1'b1);
					10: begin
						push_byte(CH_BSLASH, 1'b0, 1'b0);
						push_byte(esc_letter(), 1'b0, 1'b1);
					end
					default: ;
				endcase
			end
		endcase
	endfunction

	task automatic send_word(in_word_t w, bit typed, bit has_res, out_word_t res);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_in++;
		if (w.in_first || pmode != PM_IDLE)
			busy_items++;
		unescape_step(w);
		if (typed) begin
			if (has_res)
				exp_q.push_back(res);
		end else begin
			foreach (fresh_q[i])
				exp_q.push_back(fresh_q[i]);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (exp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(logic [15:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cap_val = v;
	endtask

	initial begin
		int start_count;
		cap_val = CAP_RESET;
		pmode = PM_IDLE;
		hex_cnt = '0;
		hex_val = '0;
		hex_bad = 1'b0;
		held = '{8'h00, 8'h00, 8'h00};
		nwritten = 0;
		dir_rows = '{
			typed_row(8'h00, 1'b1, 1'b0, 1'b1, KIND_ERROR, 16'd0),
			typed_row(8'hFF, 1'b0, 1'b0, 1'b0, KIND_DATA, 16'd0),
			typed_row(CH_QUOTE, 1'b1, 1'b1, 1'b1, KIND_DONE, 16'd0),
			cap_row(16'd3),
			typed_row(CH_QUOTE, 1'b1, 1'b0, 1'b0, KIND_DATA, 16'd0),
			// three-byte sequence does not fit
			raw(CH_BSLASH, 1'b0, 1'b0), raw(CH_U, 1'b0, 1'b0), raw("f", 1'b0, 1'b0),
			raw("F", 1'b0, 1'b0), raw("f", 1'b0, 1'b0), raw("f", 1'b0, 1'b0),
			// bad hex digit with a quote among the digits
			raw(CH_QUOTE, 1'b1, 1'b0), raw(CH_BSLASH, 1'b0, 1'b0), raw(CH_U, 1'b0, 1'b0),
			raw("g", 1'b0, 1'b0), raw(CH_QUOTE, 1'b0, 1'b0), raw("0", 1'b0, 1'b0),
			raw("0", 1'b0, 1'b0),
			// buffer ends inside the escape, replay runs out of room
			raw(CH_BSLASH, 1'b0, 1'b0), raw(CH_U, 1'b0, 1'b0), raw("7", 1'b0, 1'b0),
			raw("F", 1'b0, 1'b1),
			// restart mid-escape, then a trailing backslash
			raw(CH_QUOTE, 1'b1, 1'b0), raw(CH_BSLASH, 1'b0, 1'b0),
			raw(CH_QUOTE, 1'b1, 1'b0), raw(CH_BSLASH, 1'b0, 1'b1),
			// escape letter on the last byte
			raw(CH_QUOTE, 1'b1, 1'b0), raw(CH_BSLASH, 1'b0, 1'b0), raw(CH_N, 1'b0, 1'b1)
		};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) begin
			if (dir_rows[i].set_cap)
				write_capacity(dir_rows[i].cap);
			else
				send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].has_res,
					dir_rows[i].res);
		end
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_capacity(cap_plan[p]);
			quiet = (p == QUIET_PHASE);
			phase_no = p;
			start_count = words_in;
			while (words_in < start_count + PHASE_WORDS) begin
				build_string();
				foreach (str_q[i])
					send_word(str_q[i], 1'b0, 1'b0, '0);
			end
		end
		drain();
		$display("sent %0d input words over %0d capacity settings, %0d of them inside strings",
			words_in, NUM_PHASES + 1, busy_items);
		$display("checked %0d output words: %0d strings closed, %0d rejected, %0d mismatches",
			words_checked, strings_done, strings_bad, mism);
		if (mism == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#400000;
		$display("timeout with %0d words still expected", exp_q.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
